### design/pivot_value_partition_unit_macros.svh
// Assertion helpers for the pivot value partition unit.
`ifndef PIVOT_VALUE_PARTITION_UNIT_MACROS_SVH
`define PIVOT_VALUE_PARTITION_UNIT_MACROS_SVH

`ifndef SYNTHESIS

// Property must hold on every rising clock edge outside reset.
`define PVP_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("pvp assertion failed");

// Expression must never be true outside reset.
`define PVP_ASSERT_NEVER(lbl, clk, rst, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("pvp forbidden condition seen");

`else

`define PVP_ASSERT(lbl, clk, rst, prop)
`define PVP_ASSERT_NEVER(lbl, clk, rst, expr)

`endif

`endif

### design/pvp_pkg.sv
package pvp_pkg;

  localparam int MAX_ELEMS   = 64;
  localparam int ELEM_W      = 32;
  localparam int SPLIT_W     = 7;
  localparam int CNT_W       = SPLIT_W;
  localparam int ADDR_W      = (MAX_ELEMS > 1) ? $clog2(MAX_ELEMS) : 1;
  localparam int OUT_TDATA_W = ((ELEM_W + SPLIT_W + 7) / 8) * 8;
  localparam int OUT_PAD_W   = OUT_TDATA_W - ELEM_W - SPLIT_W;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;             // store an accepted element if the buffer is not full
    logic idx_clr;
    logic idx_inc;
    logic rd;               // read buffer at idx (port a) and split (port b)
    logic split_from_idx;
    logic split_from_count;
    logic split_inc;
    logic wr_split;         // buffer[split] <= port a data
    logic wr_idx;           // buffer[idx] <= port b data
    logic out_load;
    logic finish;           // clear count and overflow flag
  } pvp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic idx_at_end;
    logic a_gt;
    logic a_lt;
    logic out_taken;
  } pvp_status_t;

endpackage

### design/pvp_ctrl.sv
module pvp_ctrl import pvp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_last,
  output logic        in_ready,
  input  pvp_status_t status,
  output pvp_cmd_t    cmd
);

  typedef enum logic [8:0] {
    ST_IDLE      = 9'b000000001,
    ST_SCAN_RD   = 9'b000000010,
    ST_SCAN_CHK  = 9'b000000100,
    ST_SWAP_RD   = 9'b000001000,
    ST_SWAP_CHK  = 9'b000010000,
    ST_SWAP_WR   = 9'b000100000,
    ST_EMIT_RD   = 9'b001000000,
    ST_EMIT_LD   = 9'b010000000,
    ST_EMIT_WAIT = 9'b100000000
  } pvp_state_t;

  pvp_state_t state;
  pvp_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          if (in_last) begin
            cmd.idx_clr = 1'b1;
            state_next  = ST_SCAN_RD;
          end
        end
      end
      ST_SCAN_RD: begin
        if (status.idx_at_end) begin
          cmd.split_from_count = 1'b1;
          cmd.idx_clr          = 1'b1;
          state_next           = ST_EMIT_RD;
        end else begin
          cmd.rd     = 1'b1;
          state_next = ST_SCAN_CHK;
        end
      end
      ST_SCAN_CHK: begin
        cmd.idx_inc = 1'b1;
        if (status.a_gt) begin
          cmd.split_from_idx = 1'b1;
          state_next         = ST_SWAP_RD;
        end else begin
          state_next = ST_SCAN_RD;
        end
      end
      ST_SWAP_RD: begin
        if (status.idx_at_end) begin
          cmd.idx_clr = 1'b1;
          state_next  = ST_EMIT_RD;
        end else begin
          cmd.rd     = 1'b1;
          state_next = ST_SWAP_CHK;
        end
      end
      ST_SWAP_CHK: begin
        if (status.a_lt) begin
          cmd.wr_split = 1'b1;
          state_next   = ST_SWAP_WR;
        end else begin
          cmd.idx_inc = 1'b1;
          state_next  = ST_SWAP_RD;
        end
      end
      ST_SWAP_WR: begin
        cmd.wr_idx    = 1'b1;
        cmd.split_inc = 1'b1;
        cmd.idx_inc   = 1'b1;
        state_next    = ST_SWAP_RD;
      end
      ST_EMIT_RD: begin
        if (status.idx_at_end) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end else begin
          cmd.rd     = 1'b1;
          state_next = ST_EMIT_LD;
        end
      end
      ST_EMIT_LD: begin
        cmd.out_load = 1'b1;
        state_next   = ST_EMIT_WAIT;
      end
      ST_EMIT_WAIT: begin
        if (status.out_taken) begin
          cmd.idx_inc = 1'b1;
          state_next  = ST_EMIT_RD;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

### design/pvp_datapath.sv
`include "pivot_value_partition_unit_macros.svh"

module pvp_datapath import pvp_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic [ELEM_W-1:0]  in_value,
  input  logic               cfg_we,
  input  logic [ELEM_W-1:0]  cfg_wdata,
  input  pvp_cmd_t           cmd,
  output pvp_status_t        status,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [ELEM_W-1:0]  out_value,
  output logic               out_last,
  output logic [SPLIT_W-1:0] out_split,
  output logic               out_trunc
);

  logic [ELEM_W-1:0] mem [MAX_ELEMS];
  logic [ELEM_W-1:0] rd_a;
  logic [ELEM_W-1:0] rd_b;
  logic [ELEM_W-1:0] pivot;
  logic [CNT_W-1:0]  count;
  logic              overflow;
  logic [CNT_W-1:0]  idx;
  logic [CNT_W-1:0]  split;

  logic              not_full;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [ELEM_W-1:0] wr_data;

  assign not_full = count < CNT_W'(MAX_ELEMS);

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = idx[ADDR_W-1:0];
    wr_data = rd_b;
    priority if (cmd.load) begin
      wr_en   = not_full;
      wr_addr = count[ADDR_W-1:0];
      wr_data = in_value;
    end else if (cmd.wr_split) begin
      wr_en   = 1'b1;
      wr_addr = split[ADDR_W-1:0];
      wr_data = rd_a;
    end else if (cmd.wr_idx) begin
      wr_en   = 1'b1;
      wr_addr = idx[ADDR_W-1:0];
      wr_data = rd_b;
    end else begin
      wr_en   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      rd_a <= mem[idx[ADDR_W-1:0]];
      rd_b <= mem[split[ADDR_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pivot     <= '0;
      count     <= '0;
      overflow  <= 1'b0;
      idx       <= '0;
      split     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        pivot <= cfg_wdata;
      end
      if (cmd.finish) begin
        count    <= '0;
        overflow <= 1'b0;
      end else if (cmd.load) begin
        if (not_full) begin
          count <= count + CNT_W'(1);
        end else begin
          overflow <= 1'b1;
        end
      end
      if (cmd.idx_clr) begin
        idx <= '0;
      end else if (cmd.idx_inc) begin
        idx <= idx + CNT_W'(1);
      end
      priority if (cmd.split_from_count) begin
        split <= count;
      end else if (cmd.split_from_idx) begin
        split <= idx;
      end else if (cmd.split_inc) begin
        split <= split + CNT_W'(1);
      end else begin
        split <= split;
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_value <= rd_a;
      out_last  <= (idx + CNT_W'(1)) == count;
      out_split <= split;
      out_trunc <= overflow;
    end
  end

  assign status.idx_at_end = idx == count;
  assign status.a_gt       = $signed(rd_a) > $signed(pivot);
  assign status.a_lt       = $signed(rd_a) < $signed(pivot);
  assign status.out_taken  = out_valid && out_ready;

  `PVP_ASSERT(a_count_bound, clk, rst, count <= CNT_W'(MAX_ELEMS))
  `PVP_ASSERT(a_overflow_full, clk, rst, !overflow || count == CNT_W'(MAX_ELEMS))
  `PVP_ASSERT(a_split_in_range, clk, rst, !out_valid || out_split <= count)
  `PVP_ASSERT_NEVER(a_load_during_emit, clk, rst, cmd.load && out_valid)

endmodule

### design/pivot_value_partition_unit.sv
// Pivot value partition unit. Signed 32-bit elements stream in on the s_ side
// and are stored in a 64-entry buffer, one element per cycle; elements beyond
// the buffer capacity are dropped and the run is flagged as truncated. The
// transfer with s_tlast set ends the array: the unit stops taking input,
// finds the first element strictly greater than the pivot register (the
// split), then walks the rest of the buffer and swaps every element strictly
// less than the pivot into the split position, advancing the split. The
// reordered array is then sent on the m_ side, one transfer per element in
// array order, with m_tlast on the final one; every transfer carries the same
// split index and truncated flag. With no element above the pivot the split
// equals the element count and nothing moves. The scan reads and checks each
// element up to the split, the swap pass each element after it, writing both
// buffer positions for one that moves; the output pass reads each element into
// the output register and waits until it is taken before reading the next. A
// pass stops at the latest when its index reaches the element count. The
// buffer has registered read data and allows one write and two reads per
// cycle. The pivot register is written through the cfg_ port, which is always
// ready; write it only while no array is being loaded or emitted.
module pivot_value_partition_unit import pvp_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  // Element input stream.
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [ELEM_W-1:0]      s_tdata,   // [31:0] elem_value
  input  logic                   s_tlast,   // elem_last
  // Partitioned output stream.
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata,   // [31:0] out_value, [38:32] split_index,
                                            // [39] zero
  output logic                   m_tlast,   // out_last
  output logic [0:0]             m_tuser,   // [0] truncated
  // Pivot register write.
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [ELEM_W-1:0]      cfg_data   // pivot_value
);

  pvp_cmd_t           cmd;
  pvp_status_t        status;
  logic               in_ready;
  logic [ELEM_W-1:0]  out_value;
  logic [SPLIT_W-1:0] out_split;
  logic               out_trunc;

  // Config writes never stall.
  assign cfg_ready = 1'b1;
  assign s_tready  = in_ready;

  pvp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_last  (s_tlast),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  pvp_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .in_value  (s_tdata),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_wdata (cfg_data),
    .cmd       (cmd),
    .status    (status),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_value (out_value),
    .out_last  (m_tlast),
    .out_split (out_split),
    .out_trunc (out_trunc)
  );

  // Pack the result: value in the low word, split index above, zero pad.
  assign m_tdata    = {{OUT_PAD_W{1'b0}}, out_split, out_value};
  assign m_tuser[0] = out_trunc;

endmodule
